>>> design/imu_ocs_pkg.sv
// Shared types and constants for the IMU offset calibration and smoothing block.
package imu_ocs_pkg;

  // Six lanes: accel X, Y, Z then gyro X, Y, Z.
  localparam int NUM_LANES = 6;
  localparam int AXIS_W = 16;
  localparam int ACCEL_Z_LANE = 2;
  localparam int FIRST_GYRO_LANE = 3;

  localparam int CAL_LEN_W = 8;
  localparam int ONE_G_W = 15;

  // Configuration register indexes.
  localparam logic REG_CAL_LENGTH = 1'b0;
  localparam logic REG_ONE_G_COUNTS = 1'b1;

  localparam logic [CAL_LEN_W-1:0] CAL_LENGTH_RESET = 8'd200;
  localparam logic [ONE_G_W-1:0] ONE_G_COUNTS_RESET = 15'd2048;

  typedef logic signed [AXIS_W-1:0] axis_t;

  // Per-word control shared by all lanes.
  typedef struct packed {
    logic accept;     // input word taken this cycle
    logic calibrate;  // calibration word rather than measurement
    logic read_ok;    // sensor read succeeded
  } lane_ctrl_t;

endpackage

>>> design/imu_ocs_lane.sv
// One axis lane: offset tracking and first-order smoothing filter with its own state.
module imu_ocs_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  imu_ocs_pkg::lane_ctrl_t  ctrl,
  input  logic                     is_gyro,
  input  imu_ocs_pkg::axis_t       raw,
  input  imu_ocs_pkg::axis_t       drop_value,
  input  imu_ocs_pkg::axis_t       fail_value,
  output imu_ocs_pkg::axis_t       result
);

  imu_ocs_pkg::axis_t offset;
  imu_ocs_pkg::axis_t offset_next;
  imu_ocs_pkg::axis_t filt;
  imu_ocs_pkg::axis_t filt_next;

  logic signed [imu_ocs_pkg::AXIS_W:0]   avg_sum;
  imu_ocs_pkg::axis_t                    diff;
  logic signed [imu_ocs_pkg::AXIS_W+2:0] acc_f;
  logic signed [imu_ocs_pkg::AXIS_W+2:0] acc_d;
  logic signed [imu_ocs_pkg::AXIS_W+2:0] acc_sum;
  logic signed [imu_ocs_pkg::AXIS_W+3:0] gyr_f;
  logic signed [imu_ocs_pkg::AXIS_W+3:0] gyr_sum;
  imu_ocs_pkg::axis_t                    smoothed;

  // Offset moves halfway to the raw value; the run end also removes gravity.
  always_comb begin
    avg_sum = {offset[imu_ocs_pkg::AXIS_W-1], offset} + {raw[imu_ocs_pkg::AXIS_W-1], raw};
    offset_next = offset;
    if (ctrl.calibrate && ctrl.read_ok) begin
      offset_next = avg_sum[imu_ocs_pkg::AXIS_W:1] - drop_value;
    end
  end

  // Accel filter is (3*prev + 5*new) >> 3, gyro filter is (15*prev + new) >> 4.
  always_comb begin
    diff = raw - offset;
    acc_f = {{3{filt[imu_ocs_pkg::AXIS_W-1]}}, filt};
    acc_d = {{3{diff[imu_ocs_pkg::AXIS_W-1]}}, diff};
    acc_sum = (acc_f <<< 1) + acc_f + (acc_d <<< 2) + acc_d;
    gyr_f = {{4{filt[imu_ocs_pkg::AXIS_W-1]}}, filt};
    gyr_sum = (gyr_f <<< 4) - gyr_f + {{4{diff[imu_ocs_pkg::AXIS_W-1]}}, diff};
    if (is_gyro) begin
      smoothed = gyr_sum[imu_ocs_pkg::AXIS_W+3:4];
    end else begin
      smoothed = acc_sum[imu_ocs_pkg::AXIS_W+2:3];
    end
    if (ctrl.calibrate) begin
      filt_next = filt;
    end else if (ctrl.read_ok) begin
      filt_next = smoothed;
    end else begin
      filt_next = fail_value;
    end
  end

  // The result shows the updated offset or the updated filter value.
  assign result = ctrl.calibrate ? offset_next : filt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      filt <= '0;
    end else if (ctrl.accept) begin
      offset <= offset_next;
      filt <= filt_next;
    end
  end

endmodule

>>> design/imu_ocs_merge.sv
// Output stage: gathers the lane results into one registered word with its handshake.
module imu_ocs_merge (
  input  logic                                                      clk,
  input  logic                                                      rst,
  input  logic                                                      load,
  input  imu_ocs_pkg::axis_t [imu_ocs_pkg::NUM_LANES-1:0]            lane_result,
  input  logic                                                      cal_done,
  output logic                                                      space,
  output logic                                                      m_tvalid,
  input  logic                                                      m_tready,
  output logic [imu_ocs_pkg::NUM_LANES*imu_ocs_pkg::AXIS_W-1:0]     m_tdata,
  output logic                                                      m_tuser
);

  // A new word may enter when the register is empty or is being emptied.
  assign space = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload: lane 0 in the lowest bits.
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= lane_result;
      m_tuser <= cal_done;
    end
  end

endmodule

>>> design/imu_offset_calibrate_smooth_top.sv
// Top level of the IMU offset calibration and smoothing block.
// The result word of an accepted input word is registered and valid in the next cycle.
// Throughput: one word per cycle unless the output is stalled; all six axis lanes update together.
// The output register lets a new word in while the previous result is being taken.
// Reset (synchronous, active high) clears offsets, filters, the run counter and
// the output valid, and loads the configuration reset values.
module imu_offset_calibrate_smooth_top (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  s_tvalid,
  output logic                                                  s_tready,
  // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
  input  logic [imu_ocs_pkg::NUM_LANES*imu_ocs_pkg::AXIS_W-1:0] s_tdata,
  // action, read_ok
  input  logic [1:0]                                            s_tuser,
  output logic                                                  m_tvalid,
  input  logic                                                  m_tready,
  // accel_x_out, accel_y_out, accel_z_out, gyro_x_out, gyro_y_out, gyro_z_out
  output logic [imu_ocs_pkg::NUM_LANES*imu_ocs_pkg::AXIS_W-1:0] m_tdata,
  // cal_done
  output logic                                                  m_tuser,
  input  logic                                                  cfg_valid,
  output logic                                                  cfg_ready,
  input  logic                                                  cfg_index,
  input  logic [imu_ocs_pkg::ONE_G_W-1:0]                       cfg_data
);

  logic [imu_ocs_pkg::CAL_LEN_W-1:0] cal_length;
  logic [imu_ocs_pkg::ONE_G_W-1:0]   one_g_counts;
  logic [imu_ocs_pkg::CAL_LEN_W-1:0] cal_counter;
  logic [imu_ocs_pkg::CAL_LEN_W-1:0] cal_counter_next;
  logic [imu_ocs_pkg::CAL_LEN_W:0]   count_inc;
  logic                              run_done;
  logic                              space;
  imu_ocs_pkg::lane_ctrl_t           ctrl;
  imu_ocs_pkg::axis_t                one_g_axis;
  imu_ocs_pkg::axis_t [imu_ocs_pkg::NUM_LANES-1:0] raw;
  imu_ocs_pkg::axis_t [imu_ocs_pkg::NUM_LANES-1:0] lane_result;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_length <= imu_ocs_pkg::CAL_LENGTH_RESET;
      one_g_counts <= imu_ocs_pkg::ONE_G_COUNTS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        imu_ocs_pkg::REG_CAL_LENGTH:   cal_length <= cfg_data[imu_ocs_pkg::CAL_LEN_W-1:0];
        imu_ocs_pkg::REG_ONE_G_COUNTS: one_g_counts <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake and per-word control.
  assign s_tready = !rst && space;
  assign ctrl.accept = s_tvalid && s_tready;
  assign ctrl.calibrate = s_tuser[0];
  assign ctrl.read_ok = s_tuser[1];
  assign raw = s_tdata;
  assign one_g_axis = {1'b0, one_g_counts};

  // Calibration run counter: a run ends once the count reaches cal_length.
  always_comb begin
    count_inc = {1'b0, cal_counter} + 1'b1;
    run_done = ctrl.calibrate && ctrl.read_ok && (count_inc >= {1'b0, cal_length});
    cal_counter_next = run_done ? '0 : count_inc[imu_ocs_pkg::CAL_LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_counter <= '0;
    end else if (ctrl.accept && ctrl.calibrate && ctrl.read_ok) begin
      cal_counter <= cal_counter_next;
    end
  end

  // Six axis lanes; accel Z carries the gravity drop and the failed-read fallback.
  for (genvar i = 0; i < imu_ocs_pkg::NUM_LANES; i++) begin : g_lane
    imu_ocs_pkg::axis_t drop_value;
    imu_ocs_pkg::axis_t fail_value;

    assign drop_value = (i == imu_ocs_pkg::ACCEL_Z_LANE && run_done) ? one_g_axis : '0;
    assign fail_value = (i == imu_ocs_pkg::ACCEL_Z_LANE) ? one_g_axis : '0;

    imu_ocs_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .is_gyro    (i >= imu_ocs_pkg::FIRST_GYRO_LANE),
      .raw        (raw[i]),
      .drop_value (drop_value),
      .fail_value (fail_value),
      .result     (lane_result[i])
    );
  end

  imu_ocs_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (ctrl.accept),
    .lane_result (lane_result),
    .cal_done    (run_done),
    .space       (space),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

>>> design/imu_ocs_checker.sv
// Port-level checks for the IMU offset calibration and smoothing block.
module imu_ocs_checker (
  input logic                                                  clk,
  input logic                                                  rst,
  input logic                                                  s_tvalid,
  input logic                                                  s_tready,
  input logic [1:0]                                            s_tuser,
  input logic                                                  m_tvalid,
  input logic                                                  m_tready,
  input logic [imu_ocs_pkg::NUM_LANES*imu_ocs_pkg::AXIS_W-1:0] m_tdata,
  input logic                                                  m_tuser
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // Every accepted word gives a result word in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted word produced no result");

  // A measurement word never reports a finished calibration run.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser[0] |=> !m_tuser)
    else $error("cal_done raised on a measurement word");

  // A failed measurement read gives zero on every axis but accel Z.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser[0] && !s_tuser[1] |=>
      m_tdata[31:0] == 32'd0 && m_tdata[95:48] == 48'd0 && m_tdata[47] == 1'b0)
    else $error("failed read fallback values wrong");

endmodule

bind imu_offset_calibrate_smooth_top imu_ocs_checker u_imu_ocs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> test/imu_offset_calibrate_smooth_top_test.sv
// Self-checking testbench for the IMU offset calibration and smoothing top level.
module imu_offset_calibrate_smooth_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef imu_ocs_pkg::axis_t axis_t;
  localparam int NUM_LANES = imu_ocs_pkg::NUM_LANES;
  localparam int AXIS_W = imu_ocs_pkg::AXIS_W;
  localparam int ACCEL_Z_LANE = imu_ocs_pkg::ACCEL_Z_LANE;
  localparam int FIRST_GYRO_LANE = imu_ocs_pkg::FIRST_GYRO_LANE;
  localparam int CAL_LEN_W = imu_ocs_pkg::CAL_LEN_W;
  localparam int ONE_G_W = imu_ocs_pkg::ONE_G_W;
  localparam logic REG_CAL_LENGTH = imu_ocs_pkg::REG_CAL_LENGTH;
  localparam logic REG_ONE_G_COUNTS = imu_ocs_pkg::REG_ONE_G_COUNTS;
  localparam logic [CAL_LEN_W-1:0] CAL_LENGTH_RESET = imu_ocs_pkg::CAL_LENGTH_RESET;
  localparam logic [ONE_G_W-1:0] ONE_G_COUNTS_RESET = imu_ocs_pkg::ONE_G_COUNTS_RESET;

  localparam int LANES_W = NUM_LANES * AXIS_W;
  localparam logic ACT_MEASURE = 1'b0;
  localparam logic ACT_CALIBRATE = 1'b1;
  localparam axis_t AXIS_MIN = 16'sh8000;
  localparam axis_t AXIS_MAX = 16'sh7fff;
  localparam logic [ONE_G_W-1:0] ONE_G_MAX = 15'h7fff;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 4;

  // One result word: six axis lanes and the run completion flag.
  typedef struct packed {
    logic [LANES_W-1:0] lanes;
    logic cal_done;
  } imu_word_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [LANES_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [LANES_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_CAL_LENGTH;
  logic [ONE_G_W-1:0] cfg_data = '0;

  // Predicted block state and configuration.
  axis_t lane_offset [NUM_LANES] = '{default: '0};
  axis_t lane_filter [NUM_LANES] = '{default: '0};
  logic [CAL_LEN_W-1:0] run_count = '0;
  logic [CAL_LEN_W-1:0] cal_len_cfg = CAL_LENGTH_RESET;
  logic [ONE_G_W-1:0] one_g_cfg = ONE_G_COUNTS_RESET;

  imu_word_t imu_words_due [$];

  int send_idle_pct = 31;
  int recv_idle_pct = 49;
  int hold_request = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int runs_completed = 0;
  int failed_reads = 0;
  int reg_writes = 0;

  string lane_name [NUM_LANES] = '{"accel_x", "accel_y", "accel_z",
                                   "gyro_x", "gyro_y", "gyro_z"};

  imu_offset_calibrate_smooth_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Calibrate the offsets or smooth the offset-corrected sample, as the block does.
  function automatic imu_word_t calibrate_or_smooth(input logic act, input logic ok,
                                                    input logic [LANES_W-1:0] lanes);
    imu_word_t res;
    axis_t raw [NUM_LANES];
    axis_t diff;
    int sum;
    int i;
    res = '0;
    for (i = 0; i < NUM_LANES; i++) begin
      raw[i] = lanes[i*AXIS_W +: AXIS_W];
    end
    if (act == ACT_CALIBRATE) begin
      if (ok) begin
        for (i = 0; i < NUM_LANES; i++) begin
          sum = int'(lane_offset[i]) + int'(raw[i]);
          lane_offset[i] = axis_t'(sum >>> 1);
        end
        // The run ends here; gravity is taken back out of the Z offset.
        if (int'(run_count) + 1 >= int'(cal_len_cfg)) begin
          lane_offset[ACCEL_Z_LANE] =
            axis_t'(int'(lane_offset[ACCEL_Z_LANE]) - int'(one_g_cfg));
          run_count = '0;
          res.cal_done = 1'b1;
          runs_completed++;
        end else begin
          run_count = run_count + 1'b1;
        end
      end
      for (i = 0; i < NUM_LANES; i++) begin
        res.lanes[i*AXIS_W +: AXIS_W] = lane_offset[i];
      end
    end else begin
      if (ok) begin
        for (i = 0; i < NUM_LANES; i++) begin
          diff = axis_t'(int'(raw[i]) - int'(lane_offset[i]));
          if (i < FIRST_GYRO_LANE) begin
            lane_filter[i] = axis_t'((3 * int'(lane_filter[i]) + 5 * int'(diff)) >>> 3);
          end else begin
            lane_filter[i] = axis_t'((15 * int'(lane_filter[i]) + int'(diff)) >>> 4);
          end
        end
      end else begin
        // A failed read reports a level sensor at rest.
        for (i = 0; i < NUM_LANES; i++) begin
          lane_filter[i] = '0;
        end
        lane_filter[ACCEL_Z_LANE] = axis_t'({1'b0, one_g_cfg});
      end
      for (i = 0; i < NUM_LANES; i++) begin
        res.lanes[i*AXIS_W +: AXIS_W] = lane_filter[i];
      end
    end
    return res;
  endfunction

  function automatic logic [LANES_W-1:0] lanes_of(input axis_t ax, input axis_t ay,
                                                  input axis_t az, input axis_t gx,
                                                  input axis_t gy, input axis_t gz);
    return {gz, gy, gx, az, ay, ax};
  endfunction

  // Biased towards the extremes and small values around zero.
  function automatic axis_t random_axis();
    case ($urandom_range(9))
      0: return AXIS_MIN;
      1: return AXIS_MAX;
      2, 3, 4: return axis_t'($urandom_range(511) - 256);
      default: return axis_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at result %0d: %s", words_checked, msg);
    mismatch_count++;
  endtask

  // Offer one sample word and record its expected result once it is taken.
  task automatic send_word(input logic act, input logic ok, input logic [LANES_W-1:0] lanes);
    s_tvalid <= 1'b1;
    s_tdata <= lanes;
    s_tuser <= {ok, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    imu_words_due.push_back(calibrate_or_smooth(act, ok, lanes));
    words_sent++;
    if (!ok) failed_reads++;
    // Each cycle the sender stays idle with the configured chance.
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (imu_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_reg(input logic idx, input logic [ONE_G_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_CAL_LENGTH) begin
      cal_len_cfg = value[CAL_LEN_W-1:0];
    end else begin
      one_g_cfg = value;
    end
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Failed reads in both modes with the reset configuration.
  task automatic test_failed_reads();
    send_word(ACT_MEASURE, 1'b1, lanes_of(16'sd100, -16'sd100, 16'sd2000, 16'sd5, -16'sd5, 16'sd7));
    send_word(ACT_MEASURE, 1'b0, lanes_of(AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX, 16'sd1));
    send_word(ACT_CALIBRATE, 1'b0, lanes_of(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MAX, AXIS_MAX, 16'sd3));
  endtask

  // Full-scale samples through both paths.
  task automatic test_extremes();
    send_word(ACT_MEASURE, 1'b1, lanes_of(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN));
    send_word(ACT_MEASURE, 1'b1, lanes_of(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX));
    send_word(ACT_CALIBRATE, 1'b1, lanes_of(AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN));
    send_word(ACT_MEASURE, 1'b1, lanes_of(AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX));
    send_word(ACT_CALIBRATE, 1'b1, lanes_of(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN));
  endtask

  // Run completion, Z offset wrap, interrupted runs, shortened runs and a zero length.
  task automatic test_run_completion();
    drain_results();
    write_reg(REG_CAL_LENGTH, 15'd3);
    write_reg(REG_ONE_G_COUNTS, ONE_G_MAX);
    send_word(ACT_CALIBRATE, 1'b1, lanes_of(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN));
    send_word(ACT_CALIBRATE, 1'b1, lanes_of(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN));
    // A measurement in the middle must not restart the run.
    send_word(ACT_MEASURE, 1'b1, lanes_of(16'sd10, 16'sd20, 16'sd30, 16'sd40, 16'sd50, 16'sd60));
    send_word(ACT_CALIBRATE, 1'b1, lanes_of(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN));
    // Lowering the length below the count completes on the next sample.
    drain_results();
    write_reg(REG_CAL_LENGTH, 15'd5);
    repeat (3) send_word(ACT_CALIBRATE, 1'b1, lanes_of(16'sd7, 16'sd8, 16'sd9, 16'sd1, 16'sd2, 16'sd3));
    drain_results();
    write_reg(REG_CAL_LENGTH, 15'd2);
    send_word(ACT_CALIBRATE, 1'b1, lanes_of(16'sd7, 16'sd8, 16'sd9, 16'sd1, 16'sd2, 16'sd3));
    // A zero length behaves as one sample per run.
    drain_results();
    write_reg(REG_CAL_LENGTH, 15'd0);
    write_reg(REG_ONE_G_COUNTS, 15'd0);
    send_word(ACT_CALIBRATE, 1'b1, lanes_of(AXIS_MAX, 16'sd1, AXIS_MAX, 16'sd2, 16'sd3, 16'sd4));
    send_word(ACT_CALIBRATE, 1'b1, lanes_of(16'sd5, AXIS_MIN, 16'sd6, AXIS_MAX, 16'sd7, 16'sd8));
    send_word(ACT_MEASURE, 1'b0, lanes_of(16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1));
  endtask

  // Mostly whole calibration runs and measurement bursts, some broken runs and noise.
  task automatic test_random_traffic(input int n_words, input logic [CAL_LEN_W-1:0] cal_len,
                                     input logic [ONE_G_W-1:0] one_g, input int tx_idle,
                                     input int rx_idle);
    axis_t base [NUM_LANES];
    logic [LANES_W-1:0] w;
    logic act;
    logic ok;
    int sent;
    int burst;
    int kind;
    int i;
    drain_results();
    write_reg(REG_CAL_LENGTH, {{(ONE_G_W-CAL_LEN_W){1'b0}}, cal_len});
    write_reg(REG_ONE_G_COUNTS, one_g);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    sent = 0;
    while (sent < n_words) begin
      kind = $urandom_range(9);
      if (kind < 4) begin
        act = ACT_CALIBRATE;
        burst = (cal_len == 0) ? 1 : int'(cal_len);
        if (kind == 3) burst = $urandom_range(1, burst);
      end else begin
        act = ACT_MEASURE;
        burst = $urandom_range(1, 40);
      end
      for (i = 0; i < NUM_LANES; i++) begin
        base[i] = random_axis();
      end
      while (burst > 0 && sent < n_words) begin
        ok = ($urandom_range(99) >= 4);
        for (i = 0; i < NUM_LANES; i++) begin
          if (kind == 9 || $urandom_range(7) == 0) begin
            w[i*AXIS_W +: AXIS_W] = random_axis();
          end else begin
            w[i*AXIS_W +: AXIS_W] = axis_t'(int'(base[i]) + int'($urandom_range(63)) - 32);
          end
        end
        if (kind == 9) act = logic'($urandom_range(1));
        send_word(act, ok, w);
        sent++;
        burst--;
      end
    end
  endtask

  // Hold the receiver off while the sender keeps offering, then drain before more.
  task automatic test_backpressure();
    int i;
    drain_results();
    write_reg(REG_CAL_LENGTH, 15'd4);
    send_idle_pct = 0;
    hold_request = HOLD_OFF_CYCLES;
    for (i = 0; i < 30; i++) begin
      send_word(logic'($urandom_range(1)), 1'b1,
                lanes_of(random_axis(), random_axis(), random_axis(),
                         random_axis(), random_axis(), random_axis()));
    end
    drain_results();
    for (i = 0; i < 10; i++) begin
      send_word(ACT_CALIBRATE, 1'b1,
                lanes_of(random_axis(), random_axis(), random_axis(),
                         random_axis(), random_axis(), random_axis()));
    end
  endtask

  // Receiver: random ready, or a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result word with the oldest prediction.
  always @(posedge clk) begin : check_words
    imu_word_t want;
    int i;
    if (!rst && m_tvalid && m_tready) begin
      words_checked++;
      if (imu_words_due.size() == 0) begin
        report_mismatch($sformatf("result word 0x%h with none expected", m_tdata));
      end else begin
        want = imu_words_due.pop_front();
        for (i = 0; i < NUM_LANES; i++) begin
          if (m_tdata[i*AXIS_W +: AXIS_W] !== want.lanes[i*AXIS_W +: AXIS_W]) begin
            report_mismatch($sformatf("%s expected 0x%h got 0x%h", lane_name[i],
                                      want.lanes[i*AXIS_W +: AXIS_W],
                                      m_tdata[i*AXIS_W +: AXIS_W]));
          end
        end
        if (m_tuser !== want.cal_done) begin
          report_mismatch($sformatf("cal_done expected %b got %b", want.cal_done, m_tuser));
        end
      end
    end
  end

  // Watchdog: too long without any word moving on any channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles with no word moving", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_failed_reads();
    test_extremes();
    test_run_completion();

    // Sender idles less than the receiver, then the other way round, then neither.
    test_random_traffic(450, CAL_LENGTH_RESET, ONE_G_COUNTS_RESET, 31, 49);
    test_random_traffic(500, 8'd255, ONE_G_MAX, 49, 31);
    test_random_traffic(250, 8'($urandom_range(1, 20)), 15'($urandom), 0, 0);
    test_random_traffic(300, 8'd1, 15'd0, 0, 0);
    test_random_traffic(300, 8'd7, 15'($urandom), 0, 0);
    test_backpressure();

    drain_results();
    $display("Run covered %0d sample words, %0d of them failed reads, and %0d result words.",
             words_sent, failed_reads, words_checked);
    $display("Calibration runs completed: %0d over %0d register writes, lengths 0 to 255.",
             runs_completed, reg_writes);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
